// ===== rtl/kst_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kst_pkg: shared definitions for the keyed session timeout table
// field widths, action and result codes, and the shared unit result type
// ---------------------------------------------------------------------------
package kst_pkg;

	// field widths
	localparam int ACT_W  = 2;
	localparam int ID_W   = 31;
	localparam int AGE_W  = 16;
	localparam int KIND_W = 3;

	// results one tick may retire, and a counter that can hold that count
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// timeout register value after reset
	localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(60);

	// action codes
	localparam logic [ACT_W-1:0] ACT_START = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd3;

	// result kind codes
	localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd4;

	// what the shared compare and age unit reports for one slot
	typedef struct packed {
		logic             match;
		logic             due;
		logic [AGE_W-1:0] age_new;
	} unit_res_t;

endpackage

`default_nettype wire

// ===== rtl/kst_store.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kst_store: id and age memories
// one write port and one read port with registered read data
// ---------------------------------------------------------------------------
module kst_store #(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  wire                         clk,
	input  wire  [IDX_W-1:0]            rd_addr,
	output logic [kst_pkg::ID_W-1:0]    rd_id,
	output logic [kst_pkg::AGE_W-1:0]   rd_age,
	input  wire  [IDX_W-1:0]            wr_addr,
	input  wire                         id_we,
	input  wire  [kst_pkg::ID_W-1:0]    id_wdata,
	input  wire                         age_we,
	input  wire  [kst_pkg::AGE_W-1:0]   age_wdata
);
	import kst_pkg::*;

	logic [ID_W-1:0]  id_mem  [ENTRIES];
	logic [AGE_W-1:0] age_mem [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[wr_addr] <= id_wdata;
		end
		if (age_we) begin
			age_mem[wr_addr] <= age_wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_id  <= id_mem[rd_addr];
		rd_age <= age_mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/kst_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kst_unit: shared compare and age unit
// compares one slot against the key and ages it with saturation
// ---------------------------------------------------------------------------
module kst_unit (
	input  wire                        slot_valid,
	input  wire  [kst_pkg::ID_W-1:0]   slot_id,
	input  wire  [kst_pkg::AGE_W-1:0]  slot_age,
	input  wire  [kst_pkg::ID_W-1:0]   key,
	input  wire  [kst_pkg::AGE_W-1:0]  timeout,
	output kst_pkg::unit_res_t         res
);
	import kst_pkg::*;

	logic [AGE_W:0]   age_inc;
	logic [AGE_W-1:0] age_sat;

	// age plus one, saturating at the timeout
	assign age_inc = {1'b0, slot_age} + {{AGE_W{1'b0}}, 1'b1};

	always_comb begin
		if (age_inc > {1'b0, timeout}) begin
			age_sat = timeout;
		end else begin
			age_sat = age_inc[AGE_W-1:0];
		end
	end

	// key compare, entry reached its timeout, new age
	assign res = '{
		match:   slot_valid && (slot_id == key),
		due:     slot_valid && (age_sat >= timeout),
		age_new: age_sat
	};

endmodule

`default_nettype wire

// ===== rtl/keyed_session_timeout_table.sv =====
// A transaction is taken when start is high and busy is low; busy then stays high while the
// scan state walks every slot, one at a time through the shared unit, and then the finish state.
// No new transaction is taken until the scan over the memories and the finish state are over.
// Tick timeouts come out during the scan; the final result is strobed in the first busy-low cycle.
// Reset clears all valid bits and loads timeout_q with 60; no clearing pass is needed.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
// ---------------------------------------------------------------------------
// keyed_session_timeout_table: per-caller timeout timers keyed by caller id
// start, stop and query search the table, a tick ages and retires entries
// ---------------------------------------------------------------------------
module keyed_session_timeout_table #(
	parameter int ENTRIES = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_wr_en,
	input  wire  [kst_pkg::AGE_W-1:0]    cfg_wr_data,
	// command
	input  wire                          start,
	output logic                         busy,
	input  wire  [kst_pkg::ACT_W-1:0]    action,
	input  wire  [kst_pkg::ID_W-1:0]     caller_id,
	// result
	output logic                         strobe,
	output logic [kst_pkg::KIND_W-1:0]   result_kind,
	output logic [kst_pkg::ID_W-1:0]     out_caller_id,
	output logic                         is_running,
	output logic                         last
);
	import kst_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [ACT_W-1:0] act_q;
	logic [ID_W-1:0]  key_q;
	logic [AGE_W-1:0] timeout_q;
	logic [ENTRIES-1:0] valid_q;

	logic             found_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_q;
	logic [CNT_W-1:0] n_q;
	logic             pend_q;
	logic [ID_W-1:0]  pend_id_q;

	logic                strobe_q;
	logic [KIND_W-1:0]   kind_q;
	logic [ID_W-1:0]     oid_q;
	logic                run_q;
	logic                last_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             id_we;
	logic             age_we;
	logic [AGE_W-1:0] age_wdata;
	logic [ID_W-1:0]  rd_id;
	logic [AGE_W-1:0] rd_age;
	logic             slot_valid;
	logic             retire;
	logic             accept;
	unit_res_t        ures;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign slot_valid = valid_q[cnt_q];
	assign retire     = (act_q == ACT_TICK) && ures.due && (n_q != CNT_W'(MAX_RESULTS));

	// read address runs one slot ahead of the slot in the unit
	always_comb begin
		if (state_q == ST_SCAN && cnt_q != LAST_IDX) begin
			rd_addr = cnt_q + 1'b1;
		end else begin
			rd_addr = '0;
		end
	end

	// write port: age write-back during a tick scan, new entry at the end of a start
	always_comb begin
		wr_addr   = cnt_q;
		id_we     = 1'b0;
		age_we    = 1'b0;
		age_wdata = ures.age_new;
		if (state_q == ST_SCAN && act_q == ACT_TICK && slot_valid) begin
			age_we = 1'b1;
		end else if (state_q == ST_FIN && act_q == ACT_START && !found_q && free_found_q) begin
			wr_addr   = free_q;
			id_we     = 1'b1;
			age_we    = 1'b1;
			age_wdata = '0;
		end
	end

	kst_store #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.rd_id     (rd_id),
		.rd_age    (rd_age),
		.wr_addr   (wr_addr),
		.id_we     (id_we),
		.id_wdata  (key_q),
		.age_we    (age_we),
		.age_wdata (age_wdata)
	);

	kst_unit u_unit (
		.slot_valid (slot_valid),
		.slot_id    (rd_id),
		.slot_age   (rd_age),
		.key        (key_q),
		.timeout    (timeout_q),
		.res        (ures)
	);

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// operands of the current transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= caller_id;
		end
	end

	// sequencer, valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			valid_q      <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			n_q          <= '0;
			pend_q       <= 1'b0;
			pend_id_q    <= '0;
			strobe_q     <= 1'b0;
			kind_q       <= KIND_ACK;
			oid_q        <= '0;
			run_q        <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					if (accept) begin
						state_q      <= ST_SCAN;
						cnt_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						n_q          <= '0;
						pend_q       <= 1'b0;
					end
				end
				ST_SCAN: begin
					// search: note the match and the lowest free slot
					if (act_q != ACT_TICK && ures.match) begin
						found_q <= 1'b1;
						if (act_q == ACT_STOP) begin
							valid_q[cnt_q] <= 1'b0;
						end
					end
					if (!slot_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= cnt_q;
					end
					// tick: retire a due entry, flush the one held before it
					strobe_q <= retire && pend_q;
					if (retire) begin
						valid_q[cnt_q] <= 1'b0;
						n_q            <= n_q + 1'b1;
						pend_q         <= 1'b1;
						pend_id_q      <= rd_id;
						if (pend_q) begin
							kind_q   <= KIND_TIMEOUT;
							oid_q    <= pend_id_q;
							run_q    <= 1'b0;
							last_q   <= 1'b0;
						end
					end
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q  <= ST_IDLE;
					strobe_q <= 1'b1;
					last_q   <= 1'b1;
					unique case (act_q)
						ACT_START: begin
							run_q <= 1'b0;
							oid_q <= key_q;
							if (found_q) begin
								kind_q <= KIND_ACK;
							end else if (free_found_q) begin
								kind_q          <= KIND_ACK;
								valid_q[free_q] <= 1'b1;
							end else begin
								kind_q <= KIND_FULL;
							end
						end
						ACT_STOP: begin
							kind_q <= KIND_ACK;
							run_q  <= found_q;
							oid_q  <= key_q;
						end
						ACT_QUERY: begin
							kind_q <= KIND_QUERY;
							run_q  <= found_q;
							oid_q  <= key_q;
						end
						default: begin
							run_q <= 1'b0;
							if (pend_q) begin
								kind_q <= KIND_TIMEOUT;
								oid_q  <= pend_id_q;
							end else begin
								kind_q <= KIND_IDLE;
								oid_q  <= '0;
							end
						end
					endcase
				end
				default: begin
					state_q  <= ST_IDLE;
					strobe_q <= 1'b0;
				end
			endcase
		end
	end

	assign strobe        = strobe_q;
	assign result_kind   = kind_q;
	assign out_caller_id = oid_q;
	assign is_running    = run_q;
	assign last          = last_q;

endmodule

`default_nettype wire

// ===== sim/tb_keyed_session_timeout_table.sv =====
// ---------------------------------------------------------------------------
// tb_keyed_session_timeout_table: self-checking bench for the timeout table
// drives start, stop, query and tick transactions, predicts every result in
// a scoreboard that mirrors the table, and checks each strobed result in order
// ---------------------------------------------------------------------------

// one expected or observed result transaction
typedef struct packed {
	logic [kst_pkg::KIND_W-1:0] kind;
	logic [kst_pkg::ID_W-1:0]   id;
	logic                       running;
	logic                       last;
} timer_result_t;

// mirror of the timer table plus the queue of results still owed
class timer_table_model #(int SLOTS = 16);
	bit                       slot_valid [SLOTS];
	bit [kst_pkg::ID_W-1:0]   slot_id    [SLOTS];
	bit [kst_pkg::AGE_W-1:0]  slot_age   [SLOTS];
	bit [kst_pkg::AGE_W-1:0]  timeout;
	timer_result_t            owed_results [$];
	int                       errors;

	function new();
		for (int i = 0; i < SLOTS; i++) begin
			slot_valid[i] = 1'b0;
			slot_id[i]    = '0;
			slot_age[i]   = '0;
		end
		timeout = kst_pkg::TIMEOUT_RESET;
		errors  = 0;
	endfunction

	function int slot_of(bit [kst_pkg::ID_W-1:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (slot_valid[i] && slot_id[i] == id) return i;
		return -1;
	endfunction

	function void owe(logic [kst_pkg::KIND_W-1:0] kind, logic [kst_pkg::ID_W-1:0] id,
			logic running, logic last);
		timer_result_t r;
		r.kind    = kind;
		r.id      = id;
		r.running = running;
		r.last    = last;
		owed_results.push_back(r);
	endfunction

	// update the table for one accepted transaction and queue what it yields
	function void note_command(logic [kst_pkg::ACT_W-1:0] act, logic [kst_pkg::ID_W-1:0] id);
		int hit;
		int free_slot;
		int n;
		int retired [kst_pkg::MAX_RESULTS];
		bit [kst_pkg::AGE_W:0] grown;
		hit = slot_of(id);
		free_slot = -1;
		n = 0;
		case (act)
			kst_pkg::ACT_START: begin
				if (hit >= 0) begin
					owe(kst_pkg::KIND_ACK, id, 1'b0, 1'b1);
				end else begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!slot_valid[i]) free_slot = i;
					if (free_slot < 0) begin
						owe(kst_pkg::KIND_FULL, id, 1'b0, 1'b1);
					end else begin
						slot_valid[free_slot] = 1'b1;
						slot_id[free_slot]    = id;
						slot_age[free_slot]   = '0;
						owe(kst_pkg::KIND_ACK, id, 1'b0, 1'b1);
					end
				end
			end
			kst_pkg::ACT_STOP: begin
				if (hit >= 0) slot_valid[hit] = 1'b0;
				owe(kst_pkg::KIND_ACK, id, hit >= 0, 1'b1);
			end
			kst_pkg::ACT_QUERY: begin
				owe(kst_pkg::KIND_QUERY, id, hit >= 0, 1'b1);
			end
			default: begin
				// age every entry, saturate at the timeout, retire the due ones
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_valid[i]) begin
						grown = {1'b0, slot_age[i]} + 1'b1;
						if (grown > {1'b0, timeout}) grown = {1'b0, timeout};
						slot_age[i] = grown[kst_pkg::AGE_W-1:0];
						if (slot_age[i] >= timeout && n < kst_pkg::MAX_RESULTS) begin
							slot_valid[i] = 1'b0;
							retired[n] = i;
							n++;
						end
					end
				end
				if (n == 0) owe(kst_pkg::KIND_IDLE, '0, 1'b0, 1'b1);
				for (int k = 0; k < n; k++)
					owe(kst_pkg::KIND_TIMEOUT, slot_id[retired[k]], 1'b0, k == n - 1);
			end
		endcase
	endfunction

	task report(string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// compare one strobed result against the oldest owed one
	task check_result(timer_result_t got);
		timer_result_t want;
		if (owed_results.size() == 0) begin
			report($sformatf("unexpected result kind %0d id %0h", got.kind, got.id));
		end else begin
			want = owed_results.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
			if (got.id !== want.id)
				report($sformatf("out_caller_id %0h, want %0h", got.id, want.id));
			if (got.running !== want.running)
				report($sformatf("is_running %0b, want %0b", got.running, want.running));
			if (got.last !== want.last)
				report($sformatf("last %0b, want %0b", got.last, want.last));
		end
	endtask
endclass

module tb_keyed_session_timeout_table;
	localparam int TABLE_SLOTS = 16;
	localparam int SETTLE      = TABLE_SLOTS + 4;
	localparam int POOL_SIZE   = 24;
	localparam logic [kst_pkg::ID_W-1:0] ID_MAX = {kst_pkg::ID_W{1'b1}};

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [kst_pkg::AGE_W-1:0]    cfg_wr_data;
	logic                         start;
	logic                         busy;
	logic [kst_pkg::ACT_W-1:0]    action;
	logic [kst_pkg::ID_W-1:0]     caller_id;
	logic                         strobe;
	logic [kst_pkg::KIND_W-1:0]   result_kind;
	logic [kst_pkg::ID_W-1:0]     out_caller_id;
	logic                         is_running;
	logic                         last;

	timer_table_model #(TABLE_SLOTS) model;
	timer_result_t                   seen;
	logic [kst_pkg::ID_W-1:0]        id_pool [POOL_SIZE];
	int                              idle_pct;

	keyed_session_timeout_table #(
		.ENTRIES(TABLE_SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.caller_id    (caller_id),
		.strobe       (strobe),
		.result_kind  (result_kind),
		.out_caller_id(out_caller_id),
		.is_running   (is_running),
		.last         (last)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// result monitor, sampled mid-cycle away from the driving edge
	always @(negedge clk) begin
		if (arst_n && strobe) begin
			seen.kind    = result_kind;
			seen.id      = out_caller_id;
			seen.running = is_running;
			seen.last    = last;
			model.check_result(seen);
		end
	end

	// issue one transaction, with random idle cycles in front of it
	task send_command(input logic [kst_pkg::ACT_W-1:0] act, input logic [kst_pkg::ID_W-1:0] id);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		action    <= act;
		caller_id <= id;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		model.note_command(act, id);
	endtask

	// hold off until every owed result has arrived and the table is quiet
	task drain_results();
		start <= 1'b0;
		while (model.owed_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_timeout(input logic [kst_pkg::AGE_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		model.timeout = value;
	endtask

	// mostly ids from a small pool so starts, stops and queries collide
	function logic [kst_pkg::ID_W-1:0] pick_id();
		if ($urandom_range(0, 99) < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		return kst_pkg::ID_W'($urandom);
	endfunction

	task random_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)      send_command(kst_pkg::ACT_START, pick_id());
		else if (r < 55) send_command(kst_pkg::ACT_STOP, pick_id());
		else if (r < 70) send_command(kst_pkg::ACT_QUERY, pick_id());
		else             send_command(kst_pkg::ACT_TICK, kst_pkg::ID_W'($urandom));
	endtask

	// run limit
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// stimulus
	initial begin
		int phase_idle [4];
		logic [kst_pkg::AGE_W-1:0] phase_timeout [4];
		model       = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		start       = 1'b0;
		action      = kst_pkg::ACT_START;
		caller_id   = '0;
		idle_pct    = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = (i < 4) ? kst_pkg::ID_W'(i) : kst_pkg::ID_W'($urandom);
		id_pool[4] = ID_MAX;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: absent query, extreme ids, repeated start, stops
		send_command(kst_pkg::ACT_QUERY, '0);
		send_command(kst_pkg::ACT_START, ID_MAX);
		send_command(kst_pkg::ACT_START, '0);
		send_command(kst_pkg::ACT_START, '0);
		send_command(kst_pkg::ACT_QUERY, ID_MAX);
		send_command(kst_pkg::ACT_STOP, '0);
		send_command(kst_pkg::ACT_STOP, '0);
		// fill the table, then one start too many
		for (int i = 1; i < TABLE_SLOTS; i++)
			send_command(kst_pkg::ACT_START, kst_pkg::ID_W'($urandom));
		send_command(kst_pkg::ACT_START, 31'h2AAA_5555);
		// long timeout, a couple of idle ticks, then lower it so all retire at once
		write_timeout(16'hFFFF);
		send_command(kst_pkg::ACT_TICK, ID_MAX);
		send_command(kst_pkg::ACT_TICK, '0);
		write_timeout(16'd1);
		send_command(kst_pkg::ACT_TICK, '0);
		// timeout of zero retires on the very next tick
		write_timeout(16'd0);
		send_command(kst_pkg::ACT_START, 31'h5555_2AAA);
		send_command(kst_pkg::ACT_TICK, '0);
		send_command(kst_pkg::ACT_TICK, '0);

		// random phases; the receiver cannot stall, so phase 2 runs without gaps
		phase_idle[0] = 0;
		phase_idle[1] = 81;
		phase_idle[2] = 0;
		phase_idle[3] = 15;
		phase_timeout[0] = 16'd3;
		phase_timeout[1] = 16'd1;
		phase_timeout[2] = 16'hFFFF;
		phase_timeout[3] = kst_pkg::AGE_W'($urandom_range(2, 20));
		for (int p = 0; p < 4; p++) begin
			write_timeout(phase_timeout[p]);
			idle_pct = phase_idle[p];
			for (int k = 0; k < 88; k++) begin
				if (p == 1 && k == 40) drain_results();
				random_command();
			end
		end

		// wrap up
		idle_pct = 0;
		drain_results();
		if (model.owed_results.size() != 0)
			model.report($sformatf("%0d results never arrived", model.owed_results.size()));
		if (model.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ===== keyed_session_timeout_table.f =====
rtl/kst_pkg.sv
rtl/kst_store.sv
rtl/kst_unit.sv
rtl/keyed_session_timeout_table.sv
sim/tb_keyed_session_timeout_table.sv
